// File: hw/rtl/awbs_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the write burst beat serializer
// no dependencies; imported by every module of the block

package awbs_pkg;

	localparam int ADDR_W   = 64;
	localparam int ID_W     = 8;
	localparam int LEN_W    = 8;
	localparam int SIZE_W   = 3;
	localparam int BURST_W  = 2;
	localparam int DATA_W   = 64;
	localparam int STRB_W   = 8;
	// beat index is at most 255, shifted by at most 7
	localparam int OFFS_W   = 16;
	localparam int Q_DEPTH  = 2;
	localparam int Q_PTR_W  = 1;
	localparam int Q_CNT_W  = 2;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_STAGE = 2'd1,
		MODE_PUSH  = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	// one classified word, front to back
	typedef struct packed {
		logic                accepted;
		logic                beat_valid;
		logic [ID_W-1:0]     id;
		logic [ADDR_W-1:0]   base;
		logic [OFFS_W-1:0]   offset;
		logic [LEN_W-1:0]    len;
		logic [SIZE_W-1:0]   size;
		logic [BURST_W-1:0]  burst;
		logic [DATA_W-1:0]   data;
		logic [STRB_W-1:0]   strb;
		logic                last;
		logic                first;
		logic                burst_done;
	} result_t;

endpackage

// File: hw/rtl/awbs_front.sv
`timescale 1ns / 1ps
// front end: accepts words, holds burst state and classifies each request
// depends on awbs_pkg

module awbs_front import awbs_pkg::*; #(
	parameter int DATA_BITS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          mode,
	input  logic [ID_W-1:0]     aw_id,
	input  logic [ADDR_W-1:0]   aw_addr,
	input  logic [LEN_W-1:0]    aw_len,
	input  logic [SIZE_W-1:0]   aw_size,
	input  logic [BURST_W-1:0]  aw_burst,
	input  logic [DATA_W-1:0]   wr_data,
	input  logic [STRB_W-1:0]   wr_strb,
	input  logic                downstream_ready,
	output logic                res_valid,
	input  logic                res_ready,
	output result_t             res
);

	localparam int DW = (DATA_BITS < DATA_W) ? DATA_BITS : DATA_W;
	localparam int SW = ((DATA_BITS / 8) < STRB_W) ? (DATA_BITS / 8) : STRB_W;

	logic                busy_q, done_q, staged_q;
	logic [LEN_W-1:0]    pos_q;
	logic                busy_n, done_n, staged_n;
	logic [LEN_W-1:0]    pos_n;
	logic                load_en, stage_en, take;

	logic [ID_W-1:0]     id_q;
	logic [ADDR_W-1:0]   base_q;
	logic [LEN_W-1:0]    len_q;
	logic [SIZE_W-1:0]   size_q;
	logic [BURST_W-1:0]  burst_q;
	logic [DW-1:0]       sdata_q;
	logic [SW-1:0]       sstrb_q;

	assign in_ready  = res_ready;
	assign res_valid = in_valid;
	assign take      = in_valid && res_ready;

	always_comb begin
		busy_n   = busy_q;
		done_n   = done_q;
		staged_n = staged_q;
		pos_n    = pos_q;
		load_en  = 1'b0;
		stage_en = 1'b0;
		res      = '0;
		unique case (mode_t'(mode))
			MODE_START: begin
				if (!busy_q) begin
					load_en      = 1'b1;
					busy_n       = 1'b1;
					done_n       = 1'b0;
					staged_n     = 1'b0;
					pos_n        = '0;
					res.accepted = 1'b1;
				end
			end
			MODE_STAGE: begin
				// while busy the beat index is always below the beat count
				if (busy_q) begin
					stage_en     = 1'b1;
					staged_n     = 1'b1;
					res.accepted = 1'b1;
				end
			end
			MODE_PUSH: begin
				if (busy_q && staged_q && downstream_ready) begin
					res.accepted   = 1'b1;
					res.beat_valid = 1'b1;
					res.id         = id_q;
					res.base       = base_q;
					res.offset     = OFFS_W'(pos_q) << size_q;
					res.len        = len_q;
					res.size       = size_q;
					res.burst      = burst_q;
					res.data       = DATA_W'(sdata_q);
					res.strb       = STRB_W'(sstrb_q);
					res.last       = (pos_q == len_q);
					res.first      = (pos_q == '0);
					pos_n          = pos_q + 1'b1;
					staged_n       = 1'b0;
					if (pos_q == len_q) begin
						busy_n = 1'b0;
						done_n = 1'b1;
					end
				end
			end
			MODE_CLEAR: begin
				busy_n       = 1'b0;
				done_n       = 1'b0;
				staged_n     = 1'b0;
				pos_n        = '0;
				res.accepted = 1'b1;
			end
			default: begin
			end
		endcase
		res.burst_done = done_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			staged_q <= 1'b0;
			pos_q    <= '0;
		end else if (take) begin
			busy_q   <= busy_n;
			done_q   <= done_n;
			staged_q <= staged_n;
			pos_q    <= pos_n;
		end
	end

	// burst fields and staged beat are only read once their flags say so
	always_ff @(posedge clk) begin
		if (take && load_en) begin
			id_q    <= aw_id;
			base_q  <= aw_addr;
			len_q   <= aw_len;
			size_q  <= aw_size;
			burst_q <= aw_burst;
		end
		if (take && stage_en) begin
			sdata_q <= wr_data[DW-1:0];
			sstrb_q <= wr_strb[SW-1:0];
		end
	end

endmodule

// File: hw/rtl/awbs_queue.sv
`timescale 1ns / 1ps
// two-entry word queue between front and back end
// depends on awbs_pkg

module awbs_queue import awbs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  result_t  push_data,
	output logic     pop_valid,
	input  logic     pop_ready,
	output result_t  pop_data
);

	result_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0]    count_q;
	logic                  do_push, do_pop;

	assign push_ready = (count_q != Q_CNT_W'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// File: hw/rtl/awbs_back.sv
`timescale 1ns / 1ps
// back end: forms the beat address and holds the output register
// depends on awbs_pkg

module awbs_back import awbs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  result_t             q_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                accepted,
	output logic                beat_valid,
	output logic [ID_W-1:0]     beat_id,
	output logic [ADDR_W-1:0]   beat_addr,
	output logic [LEN_W-1:0]    beat_len,
	output logic [SIZE_W-1:0]   beat_size,
	output logic [BURST_W-1:0]  beat_burst,
	output logic [DATA_W-1:0]   beat_data,
	output logic [STRB_W-1:0]   beat_strb,
	output logic                beat_last,
	output logic                beat_first,
	output logic                burst_done
);

	logic valid_q;
	logic load;

	assign q_ready   = !valid_q || out_ready;
	assign load      = q_valid && q_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (q_ready)
			valid_q <= q_valid;
	end

	// base and offset are zero when no beat goes out, so the sum is too
	always_ff @(posedge clk) begin
		if (load) begin
			accepted   <= q_data.accepted;
			beat_valid <= q_data.beat_valid;
			beat_id    <= q_data.id;
			beat_addr  <= q_data.base + ADDR_W'(q_data.offset);
			beat_len   <= q_data.len;
			beat_size  <= q_data.size;
			beat_burst <= q_data.burst;
			beat_data  <= q_data.data;
			beat_strb  <= q_data.strb;
			beat_last  <= q_data.last;
			beat_first <= q_data.first;
			burst_done <= q_data.burst_done;
		end
	end

endmodule

// File: hw/rtl/axi_write_burst_beat_serializer.sv
`timescale 1ns / 1ps
// top level of the write burst beat serializer: front, queue, back
// depends on awbs_pkg, awbs_front, awbs_queue, awbs_back
//
//  channel   handshake             payload
//  input     in_valid / in_ready   mode, aw_*, wr_data, wr_strb, downstream_ready
//  output    out_valid / out_ready accepted, beat_*, burst_done
//
// one word per clock sustained while out_ready holds; taken words are queued, then registered
// the front updates burst state in the cycle a word is taken, the back adds the address
// a two-word queue sits between them, so in_ready drops only when the queue is full
// a stalled output holds its result while the queue takes words until it is full
// arst_n clears the burst state and empties queue and output register

module axi_write_burst_beat_serializer import awbs_pkg::*; #(
	parameter int DATA_BITS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          mode,
	input  logic [ID_W-1:0]     aw_id,
	input  logic [ADDR_W-1:0]   aw_addr,
	input  logic [LEN_W-1:0]    aw_len,
	input  logic [SIZE_W-1:0]   aw_size,
	input  logic [BURST_W-1:0]  aw_burst,
	input  logic [DATA_W-1:0]   wr_data,
	input  logic [STRB_W-1:0]   wr_strb,
	input  logic                downstream_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                accepted,
	output logic                beat_valid,
	output logic [ID_W-1:0]     beat_id,
	output logic [ADDR_W-1:0]   beat_addr,
	output logic [LEN_W-1:0]    beat_len,
	output logic [SIZE_W-1:0]   beat_size,
	output logic [BURST_W-1:0]  beat_burst,
	output logic [DATA_W-1:0]   beat_data,
	output logic [STRB_W-1:0]   beat_strb,
	output logic                beat_last,
	output logic                beat_first,
	output logic                burst_done
);

	result_t fr_res, q_res;
	logic    fr_valid, fr_ready, q_valid, q_ready;

	awbs_front #(
		.DATA_BITS(DATA_BITS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.aw_id            (aw_id),
		.aw_addr          (aw_addr),
		.aw_len           (aw_len),
		.aw_size          (aw_size),
		.aw_burst         (aw_burst),
		.wr_data          (wr_data),
		.wr_strb          (wr_strb),
		.downstream_ready (downstream_ready),
		.res_valid        (fr_valid),
		.res_ready        (fr_ready),
		.res              (fr_res)
	);

	awbs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  (fr_res),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_res)
	);

	awbs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_data     (q_res),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.accepted   (accepted),
		.beat_valid (beat_valid),
		.beat_id    (beat_id),
		.beat_addr  (beat_addr),
		.beat_len   (beat_len),
		.beat_size  (beat_size),
		.beat_burst (beat_burst),
		.beat_data  (beat_data),
		.beat_strb  (beat_strb),
		.beat_last  (beat_last),
		.beat_first (beat_first),
		.burst_done (burst_done)
	);

endmodule

// File: hw/rtl/awbs_checker.sv
`timescale 1ns / 1ps
// port-level checks on the write burst beat serializer, bound to the top level
// depends on awbs_pkg and axi_write_burst_beat_serializer

module awbs_checker import awbs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic                accepted,
	input  logic                beat_valid,
	input  logic [ADDR_W-1:0]   beat_addr,
	input  logic [LEN_W-1:0]    beat_len,
	input  logic [DATA_W-1:0]   beat_data,
	input  logic                beat_last,
	input  logic                beat_first,
	input  logic                burst_done
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(beat_addr) && $stable(beat_data)
		&& $stable(accepted))
		else $error("output word changed while stalled");

	a_beat_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && beat_valid |-> accepted)
		else $error("beat emitted without acceptance");

	a_no_beat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !beat_valid |-> beat_addr == '0 && beat_data == '0
		&& !beat_last && !beat_first)
		else $error("beat fields not cleared on a word without a beat");

	// on a word with a beat, completion shows up only with the final beat
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && beat_valid && burst_done |-> beat_last)
		else $error("burst done on a beat that is not last");

	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && beat_valid && beat_first && beat_last |-> beat_len == '0)
		else $error("first and last beat on a multi-beat burst");

endmodule

bind axi_write_burst_beat_serializer awbs_checker u_awbs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.accepted   (accepted),
	.beat_valid (beat_valid),
	.beat_addr  (beat_addr),
	.beat_len   (beat_len),
	.beat_data  (beat_data),
	.beat_last  (beat_last),
	.beat_first (beat_first),
	.burst_done (burst_done)
);

// File: bench/tb_axi_write_burst_beat_serializer.sv
`timescale 1ns / 1ps
// testbench for axi_write_burst_beat_serializer: directed then random burst traffic
// self-checking scoreboard tracks burst state and compares every result word
// depends on awbs_pkg and the serializer rtl

module tb_axi_write_burst_beat_serializer;
	import awbs_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_WORDS = 800;
	localparam int QUIET_AFTER = 700;

	typedef struct {
		mode_t               mode;
		logic [ID_W-1:0]     id;
		logic [ADDR_W-1:0]   addr;
		logic [LEN_W-1:0]    len;
		logic [SIZE_W-1:0]   size;
		logic [BURST_W-1:0]  burst;
		logic [DATA_W-1:0]   data;
		logic [STRB_W-1:0]   strb;
		logic                ds_ready;
	} write_cmd_t;

	typedef struct {
		logic                accepted;
		logic                beat_valid;
		logic [ID_W-1:0]     id;
		logic [ADDR_W-1:0]   addr;
		logic [LEN_W-1:0]    len;
		logic [SIZE_W-1:0]   size;
		logic [BURST_W-1:0]  burst;
		logic [DATA_W-1:0]   data;
		logic [STRB_W-1:0]   strb;
		logic                last;
		logic                first;
		logic                burst_done;
	} beat_word_t;

	class burst_scoreboard;
		bit                 busy;
		bit [ID_W-1:0]      id_q;
		bit [ADDR_W-1:0]    base_q;
		bit [LEN_W-1:0]     len_q;
		bit [SIZE_W-1:0]    size_q;
		bit [BURST_W-1:0]   burst_q;
		bit [8:0]           total_q;
		bit [8:0]           pos_q;
		bit [8:0]           done_q;
		bit [DATA_W-1:0]    data_q;
		bit [STRB_W-1:0]    strb_q;
		bit                 staged;
		beat_word_t         expected_beats[$];
		int unsigned        mismatches = 0;

		function void clear_state();
			busy = 0; id_q = '0; base_q = '0; len_q = '0; size_q = '0; burst_q = '0;
			total_q = '0; pos_q = '0; done_q = '0; data_q = '0; strb_q = '0; staged = 0;
		endfunction

		function void note_word(write_cmd_t w);
			beat_word_t e;
			e = '{default: '0};
			case (w.mode)
				MODE_START: begin
					if (!busy) begin
						id_q = w.id; base_q = w.addr; len_q = w.len;
						size_q = w.size; burst_q = w.burst;
						total_q = {1'b0, w.len} + 9'd1;
						pos_q = '0; done_q = '0; staged = 0; busy = 1;
						e.accepted = 1;
					end
				end
				MODE_STAGE: begin
					if (busy && pos_q < total_q) begin
						data_q = w.data; strb_q = w.strb; staged = 1;
						e.accepted = 1;
					end
				end
				MODE_PUSH: begin
					if (busy && staged && pos_q < total_q && w.ds_ready) begin
						e.accepted = 1;
						e.beat_valid = 1;
						e.id = id_q;
						// incr address wraps at 64 bits
						e.addr = base_q + (ADDR_W'(pos_q) << size_q);
						e.len = len_q;
						e.size = size_q;
						e.burst = burst_q;
						e.data = data_q;
						e.strb = strb_q;
						e.last = (pos_q + 9'd1 == total_q);
						e.first = (pos_q == 9'd0);
						pos_q = pos_q + 9'd1;
						done_q = done_q + 9'd1;
						staged = 0;
						if (pos_q >= total_q)
							busy = 0;
					end
				end
				default: begin
					clear_state();
					e.accepted = 1;
				end
			endcase
			e.burst_done = !busy && total_q != 0 && done_q == total_q;
			expected_beats = {expected_beats, e};
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s: expected %h, got %h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(beat_word_t got);
			beat_word_t e;
			if (expected_beats.size() == 0) begin
				$error("result word arrived with no expectation waiting");
				mismatches++;
			end else begin
				e = expected_beats.pop_front();
				compare_field("accepted", e.accepted, got.accepted);
				compare_field("beat_valid", e.beat_valid, got.beat_valid);
				compare_field("beat_id", e.id, got.id);
				compare_field("beat_addr", e.addr, got.addr);
				compare_field("beat_len", e.len, got.len);
				compare_field("beat_size", e.size, got.size);
				compare_field("beat_burst", e.burst, got.burst);
				compare_field("beat_data", e.data, got.data);
				compare_field("beat_strb", e.strb, got.strb);
				compare_field("beat_last", e.last, got.last);
				compare_field("beat_first", e.first, got.first);
				compare_field("burst_done", e.burst_done, got.burst_done);
			end
		endfunction

		function int unsigned pending();
			return expected_beats.size();
		endfunction
	endclass

	logic                clk = 0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          mode;
	logic [ID_W-1:0]     aw_id;
	logic [ADDR_W-1:0]   aw_addr;
	logic [LEN_W-1:0]    aw_len;
	logic [SIZE_W-1:0]   aw_size;
	logic [BURST_W-1:0]  aw_burst;
	logic [DATA_W-1:0]   wr_data;
	logic [STRB_W-1:0]   wr_strb;
	logic                downstream_ready;
	logic                out_valid;
	logic                out_ready;
	logic                accepted;
	logic                beat_valid;
	logic [ID_W-1:0]     beat_id;
	logic [ADDR_W-1:0]   beat_addr;
	logic [LEN_W-1:0]    beat_len;
	logic [SIZE_W-1:0]   beat_size;
	logic [BURST_W-1:0]  beat_burst;
	logic [DATA_W-1:0]   beat_data;
	logic [STRB_W-1:0]   beat_strb;
	logic                beat_last;
	logic                beat_first;
	logic                burst_done;

	burst_scoreboard sb = new;
	int unsigned words_sent = 0;
	int unsigned cycle_count = 0;
	bit quiet = 0;
	bit idle_phase = 1;

	axi_write_burst_beat_serializer #(.DATA_BITS(64)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .aw_id(aw_id), .aw_addr(aw_addr), .aw_len(aw_len),
		.aw_size(aw_size), .aw_burst(aw_burst), .wr_data(wr_data), .wr_strb(wr_strb),
		.downstream_ready(downstream_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.accepted(accepted), .beat_valid(beat_valid), .beat_id(beat_id),
		.beat_addr(beat_addr), .beat_len(beat_len), .beat_size(beat_size),
		.beat_burst(beat_burst), .beat_data(beat_data), .beat_strb(beat_strb),
		.beat_last(beat_last), .beat_first(beat_first), .burst_done(burst_done)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// every field random so unused bits toggle too
	function automatic write_cmd_t rand_word(mode_t m);
		write_cmd_t w;
		w.mode = m;
		w.id = ID_W'($urandom_range(0, 255));
		w.addr = rand64();
		w.len = LEN_W'($urandom_range(0, 255));
		w.size = SIZE_W'($urandom_range(0, 7));
		w.burst = BURST_W'($urandom_range(0, 3));
		w.data = rand64();
		w.strb = STRB_W'($urandom_range(0, 255));
		w.ds_ready = 1'($urandom_range(0, 1));
		return w;
	endfunction

	task automatic send_word(write_cmd_t w);
		if (words_sent % 40 == 0)
			idle_phase = ($urandom_range(0, 3) != 0);
		if (!quiet && idle_phase && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= w.mode;
		aw_id <= w.id;
		aw_addr <= w.addr;
		aw_len <= w.len;
		aw_size <= w.size;
		aw_burst <= w.burst;
		wr_data <= w.data;
		wr_strb <= w.strb;
		downstream_ready <= w.ds_ready;
		do @(posedge clk); while (!in_ready);
		sb.note_word(w);
		words_sent++;
	endtask

	task automatic do_start(logic [ID_W-1:0] id, logic [ADDR_W-1:0] addr,
			logic [LEN_W-1:0] len, logic [SIZE_W-1:0] size, logic [BURST_W-1:0] burst);
		write_cmd_t w;
		w = rand_word(MODE_START);
		w.id = id; w.addr = addr; w.len = len; w.size = size; w.burst = burst;
		send_word(w);
	endtask

	task automatic do_stage(logic [DATA_W-1:0] data, logic [STRB_W-1:0] strb);
		write_cmd_t w;
		w = rand_word(MODE_STAGE);
		w.data = data; w.strb = strb;
		send_word(w);
	endtask

	task automatic do_push(logic rdy);
		write_cmd_t w;
		w = rand_word(MODE_PUSH);
		w.ds_ready = rdy;
		send_word(w);
	endtask

	task automatic do_clear();
		send_word(rand_word(MODE_CLEAR));
	endtask

	// one burst with random content; noise_pct sets how often a stray word gets in
	task automatic run_burst(logic [LEN_W-1:0] len, logic [SIZE_W-1:0] size, int noise_pct);
		logic [ADDR_W-1:0] addr;
		addr = rand64();
		// sometimes start near the top so the address wraps
		if ($urandom_range(0, 7) == 0)
			addr = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 4095));
		do_start(ID_W'($urandom_range(0, 255)), addr, len, size,
			BURST_W'($urandom_range(0, 3)));
		for (int i = 0; i <= len; i++) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_word(rand_word(mode_t'($urandom_range(0, 3))));
			if ($urandom_range(0, 99) < noise_pct)
				do_push(1'b1);
			do_stage(rand64(), STRB_W'($urandom_range(0, 255)));
			if ($urandom_range(0, 99) < noise_pct)
				do_stage(rand64(), STRB_W'($urandom_range(0, 255)));
			if ($urandom_range(0, 99) < 2 * noise_pct)
				do_push(1'b0);
			do_push(1'b1);
		end
	endtask

	// result side: check each taken word, stall in random bursts
	initial begin
		beat_word_t got;
		int stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.accepted = accepted;
				got.beat_valid = beat_valid;
				got.id = beat_id;
				got.addr = beat_addr;
				got.len = beat_len;
				got.size = beat_size;
				got.burst = beat_burst;
				got.data = beat_data;
				got.strb = beat_strb;
				got.last = beat_last;
				got.first = beat_first;
				got.burst_done = burst_done;
				sb.check_result(got);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!quiet && idle_phase && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 6) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int long_done;
		long_done = 0;
		sb.clear_state();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_CLEAR;
		aw_id <= '0;
		aw_addr <= '0;
		aw_len <= '0;
		aw_size <= '0;
		aw_burst <= '0;
		wr_data <= '0;
		wr_strb <= '0;
		downstream_ready <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: rejects while idle, top address wrap, overwrite, not-ready push
		do_push(1'b1);
		do_stage(rand64(), 8'hFF);
		do_start(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'd1, 3'd7, 2'd3);
		do_start(8'h00, 64'h0, 8'd0, 3'd0, 2'd0);
		do_push(1'b1);
		do_stage(64'h0, 8'h00);
		do_stage(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
		do_push(1'b0);
		do_push(1'b1);
		do_stage(rand64(), STRB_W'($urandom_range(0, 255)));
		do_push(1'b1);
		do_stage(rand64(), 8'h5A);
		do_push(1'b1);
		// single beat burst, then clear drops burst_done
		do_start(8'h00, 64'h0, 8'd0, 3'd0, 2'd0);
		do_stage(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
		do_push(1'b1);
		do_clear();
		// longest burst, cleared mid-way
		do_start(8'hA5, 64'h8000_0000_0000_0000, 8'd255, 3'd3, 2'd1);
		do_stage(64'h0, 8'h00);
		do_push(1'b1);
		do_clear();
		do_start(8'h3C, rand64(), 8'd2, 3'd5, 2'd2);
		do_clear();

		// random bursts; one full 256-beat burst at size 7 reaches the widest offset
		while (words_sent < RANDOM_WORDS) begin
			quiet = (words_sent >= QUIET_AFTER);
			if (!long_done && words_sent > 120) begin
				run_burst(8'd255, 3'd7, 0);
				long_done = 1;
			end else begin
				case ($urandom_range(0, 9))
					0: send_word(rand_word(mode_t'($urandom_range(0, 3))));
					1: run_burst(LEN_W'($urandom_range(8, 40)),
						SIZE_W'($urandom_range(0, 7)), 10);
					default: run_burst(LEN_W'($urandom_range(0, 7)),
						SIZE_W'($urandom_range(0, 7)), 10);
				endcase
				if ($urandom_range(0, 3) == 0)
					do_clear();
			end
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
